@@ rtl/core/icgp_pkg.sv @@
// Shared types and constants for the inode cache get/put block.
package icgp_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_IN_W  = 6;
  localparam int FS_W       = 8;
  localparam int NODE_W     = 31;
  localparam int PID_W      = 15;
  localparam int LOCK_W     = 8;
  localparam int EV_W       = 32;
  localparam int STATUS_W   = 3;

  localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_WAIT   = 3'd2,
    ST_NOFREE = 3'd3,
    ST_HELD   = 3'd4,
    ST_FREED  = 3'd5,
    ST_ERROR  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EVAL
  } state_t;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_MISS,
    OP_PUT
  } op_t;

  typedef struct packed {
    logic [FS_W-1:0]   fs;
    logic [NODE_W-1:0] node;
  } key_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    key_t              key;
  } key_wr_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] idx;
  } srch_res_t;

  typedef struct packed {
    logic              unlink;
    logic              append;
    logic [SLOT_W-1:0] slot;
  } fl_cmd_t;

endpackage

@@ rtl/core/icgp_req_if.sv @@
// Request channel: get by key or put by slot, with valid/ready handshake.
interface icgp_req_if import icgp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [FS_W-1:0]      fs_number;
  logic [NODE_W-1:0]    node_number;
  logic [PID_W-1:0]     process_id;
  logic [SLOT_IN_W-1:0] slot;

  modport source (
    output valid, action, fs_number, node_number, process_id, slot,
    input  ready
  );

  modport sink (
    input  valid, action, fs_number, node_number, process_id, slot,
    output ready
  );
endinterface

@@ rtl/core/icgp_rsp_if.sv @@
// Response channel: status, slot, wake event id and wake flag, with valid/ready handshake.
interface icgp_rsp_if import icgp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_IN_W-1:0] slot_out;
  logic [EV_W-1:0]      event_id;
  logic                 wake;

  modport source (
    output valid, status, slot_out, event_id, wake,
    input  ready
  );

  modport sink (
    input  valid, status, slot_out, event_id, wake,
    output ready
  );
endinterface

@@ rtl/core/icgp_key_search.sv @@
// Key store with a sequential full-key search, one slot compared per cycle.
module icgp_key_search import icgp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  key_t              key,
  input  key_wr_t           ins,
  input  logic [SLOT_W-1:0] chk_idx,
  output logic              chk_valid,
  output srch_res_t         res
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  key_t                 key_mem [NUM_SLOTS];
  key_t                 rd_key;
  logic [NUM_SLOTS-1:0] kvalid;
  logic                 busy;
  logic                 cmp_valid;
  logic [SLOT_W-1:0]    scan_idx;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 match;
  logic                 last;

  always_ff @(posedge clk) begin
    rd_key <= key_mem[scan_idx];
    if (ins.en) begin
      key_mem[ins.idx] <= ins.key;
    end
  end

  // The compare stage sees the entry that was addressed in the cycle before.
  assign match = cmp_valid && kvalid[cmp_idx] && (rd_key == key);
  assign last  = (cmp_idx == LAST_IDX);

  assign res.done  = busy && cmp_valid && (match || last);
  assign res.found = match;
  assign res.idx   = cmp_idx;

  assign chk_valid = kvalid[chk_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid    <= '0;
      busy      <= 1'b0;
      cmp_valid <= 1'b0;
      scan_idx  <= '0;
      cmp_idx   <= '0;
    end else begin
      if (ins.en) begin
        kvalid[ins.idx] <= 1'b1;
      end
      if (start) begin
        busy      <= 1'b1;
        cmp_valid <= 1'b0;
        scan_idx  <= '0;
      end else if (busy) begin
        if (res.done) begin
          busy      <= 1'b0;
          cmp_valid <= 1'b0;
        end else begin
          cmp_valid <= 1'b1;
          cmp_idx   <= scan_idx;
          scan_idx  <= scan_idx + SLOT_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/core/icgp_free_list.sv @@
// Free list kept as a doubly linked list in two link memories, oldest release at the head.
module icgp_free_list import icgp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] rd_slot,
  input  fl_cmd_t           cmd,
  output logic [SLOT_W-1:0] head,
  output logic [CNT_W-1:0]  count
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  logic [SLOT_W-1:0]    next_mem [NUM_SLOTS];
  logic [SLOT_W-1:0]    prev_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] nvalid;
  logic [NUM_SLOTS-1:0] pvalid;
  logic [SLOT_W-1:0]    next_rd;
  logic [SLOT_W-1:0]    prev_rd;
  logic [SLOT_W-1:0]    rd_q;
  logic [SLOT_W-1:0]    tail;
  logic [SLOT_W-1:0]    nxt;
  logic [SLOT_W-1:0]    prv;

  logic                 nx_we;
  logic [SLOT_W-1:0]    nx_wa;
  logic [SLOT_W-1:0]    nx_wd;
  logic                 pv_we;
  logic [SLOT_W-1:0]    pv_wa;
  logic [SLOT_W-1:0]    pv_wd;

  // Links never written still hold their reset order: slot i sits between i-1 and i+1.
  assign nxt = nvalid[rd_q] ? next_rd : rd_q + SLOT_W'(1);
  assign prv = pvalid[rd_q] ? prev_rd : rd_q - SLOT_W'(1);

  always_comb begin
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    pv_we = 1'b0;
    pv_wa = '0;
    pv_wd = '0;
    if (cmd.unlink) begin
      if (cmd.slot != head) begin
        nx_we = 1'b1;
        nx_wa = prv;
        nx_wd = nxt;
      end
      if (cmd.slot != tail) begin
        pv_we = 1'b1;
        pv_wa = nxt;
        pv_wd = prv;
      end
    end else if (cmd.append && (count != '0)) begin
      nx_we = 1'b1;
      nx_wa = tail;
      nx_wd = cmd.slot;
      pv_we = 1'b1;
      pv_wa = cmd.slot;
      pv_wd = tail;
    end
  end

  always_ff @(posedge clk) begin
    next_rd <= next_mem[rd_slot];
    prev_rd <= prev_mem[rd_slot];
    rd_q    <= rd_slot;
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= LAST_IDX;
      count  <= CNT_W'(NUM_SLOTS);
      nvalid <= '0;
      pvalid <= '0;
    end else begin
      if (nx_we) begin
        nvalid[nx_wa] <= 1'b1;
      end
      if (pv_we) begin
        pvalid[pv_wa] <= 1'b1;
      end
      if (cmd.unlink) begin
        if (cmd.slot == head) begin
          head <= nxt;
        end
        if (cmd.slot == tail) begin
          tail <= prv;
        end
        count <= count - CNT_W'(1);
      end else if (cmd.append) begin
        if (count == '0) begin
          head <= cmd.slot;
        end
        tail  <= cmd.slot;
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/inode_cache_get_put.sv @@
// A get scans the keys one slot per cycle until a hit or the last slot, then reads and evaluates
// the slot; a put skips the scan. Only one transaction is in flight at a time.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, active high) empties the cache at once: all keys invalid, all locks zero,
// the free list holds every slot in order and the event counter restarts at zero.
module inode_cache_get_put import icgp_pkg::*; (
  input logic       clk,
  input logic       rst,
  icgp_req_if.sink  req,
  icgp_rsp_if.source rsp
);

  // Per-slot lock state: nesting count and the process that holds the lock.
  typedef struct packed {
    logic [LOCK_W-1:0] lock;
    logic [PID_W-1:0]  pid;
  } slot_ent_t;

  // Slot state and event memories, read at the current slot every cycle.
  slot_ent_t            slot_mem  [NUM_SLOTS];
  logic [EV_W-1:0]      event_mem [NUM_SLOTS];
  slot_ent_t            slot_rd;
  logic [EV_W-1:0]      ev_rd;
  logic [NUM_SLOTS-1:0] ev_valid;
  logic [EV_W-1:0]      next_event;

  // Sequencer and the captured request.
  state_t               state;
  state_t               state_next;
  op_t                  op;
  logic [SLOT_W-1:0]    cur;
  key_t                 req_key;
  logic [PID_W-1:0]     req_pid;
  logic [SLOT_IN_W-1:0] req_slot;

  logic                 accept;
  logic                 srch_start;
  logic                 commit;
  logic                 out_free;

  // Result register toward the response channel.
  logic                 out_valid;
  status_t              out_status;
  logic [SLOT_IN_W-1:0] out_slot;
  logic [EV_W-1:0]      out_event;
  logic                 out_wake;

  // Interfaces to the search unit and the free list.
  srch_res_t            srch_res;
  key_wr_t              ins;
  logic                 chk_valid;
  fl_cmd_t              fl_cmd;
  logic [SLOT_W-1:0]    fl_head;
  logic [CNT_W-1:0]     fl_count;

  // Outcome of the evaluation step, applied only when the transaction commits.
  status_t              res_status;
  logic [SLOT_IN_W-1:0] res_slot;
  logic [EV_W-1:0]      res_event;
  logic                 res_wake;
  logic                 slot_we;
  slot_ent_t            slot_wd;
  logic                 evm_we;
  logic                 evv_set;
  logic                 evv_clr;
  logic                 ne_inc;
  logic                 ins_en;
  logic                 fl_unlink;
  logic                 fl_append;

  logic [LOCK_W-1:0]    cur_lock;
  logic                 cur_has_ev;
  logic [EV_W-1:0]      ev_val;
  logic                 slot_bad;

  icgp_key_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (srch_start),
    .key       (req_key),
    .ins       (ins),
    .chk_idx   (cur),
    .chk_valid (chk_valid),
    .res       (srch_res)
  );

  icgp_free_list u_free (
    .clk     (clk),
    .rst     (rst),
    .rd_slot (cur),
    .cmd     (fl_cmd),
    .head    (fl_head),
    .count   (fl_count)
  );

  assign req.ready    = (state == S_IDLE);
  assign out_free     = !out_valid || rsp.ready;

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.slot_out = out_slot;
  assign rsp.event_id = out_event;
  assign rsp.wake     = out_wake;

  assign ins    = '{en: commit && ins_en, idx: cur, key: req_key};
  assign fl_cmd = '{unlink: commit && fl_unlink, append: commit && fl_append, slot: cur};

  // Sequencer: a get scans the keys, then every transaction reads the slot state in S_READ
  // and evaluates in the next state, S_EVAL. Evaluation holds until the result register is free,
  // and the memory reads keep the same address, so their data stays valid while it waits.
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    srch_start = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          accept     = 1'b1;
          srch_start = !req.action;
          state_next = req.action ? S_READ : S_SCAN;
        end
      end
      S_SCAN: begin
        if (srch_res.done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A slot whose key was never installed has never been locked, so its count reads as zero.
  assign cur_lock   = chk_valid ? slot_rd.lock : '0;
  assign cur_has_ev = ev_valid[cur];
  assign ev_val     = cur_has_ev ? ev_rd : next_event;
  assign slot_bad   = ((SLOT_IN_W + 1)'(req_slot) >= (SLOT_IN_W + 1)'(NUM_SLOTS));

  // Evaluation of the current slot. Each outcome touches at most one entry of each memory,
  // one free list operation and the event counter.
  always_comb begin
    res_status = ST_ERROR;
    res_slot   = SLOT_IN_W'(cur);
    res_event  = '0;
    res_wake   = 1'b0;
    slot_we    = 1'b0;
    slot_wd    = slot_rd;
    evm_we     = 1'b0;
    evv_set    = 1'b0;
    evv_clr    = 1'b0;
    ne_inc     = 1'b0;
    ins_en     = 1'b0;
    fl_unlink  = 1'b0;
    fl_append  = 1'b0;
    case (op)
      OP_HIT: begin
        if (cur_lock != '0) begin
          if (slot_rd.pid == req_pid) begin
            // Nested lock by the holder; a full count is refused unchanged.
            if (cur_lock < LOCK_MAX) begin
              res_status   = ST_HIT;
              slot_we      = 1'b1;
              slot_wd.lock = cur_lock + LOCK_W'(1);
            end
          end else begin
            // Held by another process: hand out the key's wake event, creating it if needed.
            res_status = ST_WAIT;
            res_event  = ev_val;
            if (!cur_has_ev) begin
              evm_we  = 1'b1;
              evv_set = 1'b1;
              ne_inc  = 1'b1;
            end
          end
        end else begin
          // Cached but unlocked: lock it and pull it out of the free list.
          res_status = ST_HIT;
          slot_we    = 1'b1;
          slot_wd    = '{lock: LOCK_W'(1), pid: req_pid};
          fl_unlink  = 1'b1;
        end
      end
      OP_MISS: begin
        if (fl_count == '0) begin
          res_status = ST_NOFREE;
          res_slot   = '0;
        end else begin
          // Recycle the least recently released slot under the new key.
          res_status = ST_NEW;
          slot_we    = 1'b1;
          slot_wd    = '{lock: LOCK_W'(1), pid: req_pid};
          ins_en     = 1'b1;
          evv_clr    = 1'b1;
          fl_unlink  = 1'b1;
        end
      end
      OP_PUT: begin
        res_slot = req_slot;
        if (!slot_bad && (cur_lock != '0)) begin
          slot_we      = 1'b1;
          slot_wd.lock = cur_lock - LOCK_W'(1);
          if (cur_lock != LOCK_W'(1)) begin
            res_status = ST_HELD;
          end else begin
            // Last unlock: report and drop the wake event, then queue the slot at the tail.
            res_status = ST_FREED;
            res_event  = ev_val;
            res_wake   = 1'b1;
            ne_inc     = !cur_has_ev;
            evv_clr    = 1'b1;
            fl_append  = 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_rd <= slot_mem[cur];
    ev_rd   <= event_mem[cur];
    if (commit && slot_we) begin
      slot_mem[cur] <= slot_wd;
    end
    if (commit && evm_we) begin
      event_mem[cur] <= next_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ev_valid   <= '0;
      next_event <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && evv_set) begin
        ev_valid[cur] <= 1'b1;
      end
      if (commit && evv_clr) begin
        ev_valid[cur] <= 1'b0;
      end
      if (commit && ne_inc) begin
        next_event <= next_event + EV_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured request, current slot and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_key  <= '{fs: req.fs_number, node: req.node_number};
      req_pid  <= req.process_id;
      req_slot <= req.slot;
      cur      <= req.slot[SLOT_W-1:0];
      op       <= req.action ? OP_PUT : OP_MISS;
    end else if ((state == S_SCAN) && srch_res.done) begin
      // A miss works on the free-list head, which stays put until this transaction commits.
      cur <= srch_res.found ? srch_res.idx : fl_head;
      op  <= srch_res.found ? OP_HIT : OP_MISS;
    end
    if (commit) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_event  <= res_event;
      out_wake   <= res_wake;
    end
  end

endmodule
